### rtl/core/ntrq_pkg.sv
// Package for the neighbour table: operation codes, state encoding and beat types.
// Used by the table top level, its checker and the bench; depends on nothing.
package ntrq_pkg;

	// Width of the entry count field of a result beat.
	localparam int CNT_W = 5;

	// Operation codes carried in the func field.
	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_ERASE  = 2'd1,
		FUNC_LOOKUP = 2'd2,
		FUNC_NOP    = 2'd3
	} func_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// One stored entry as held in the entry memory.
	typedef struct packed {
		logic [31:0] addr;
		logic [7:0]  will;
	} entry_t;

	// Request beat.
	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] neighbor_addr;
		logic [7:0]  willingness;
		logic        match_willingness;
	} req_t;

	// Response beat.
	typedef struct packed {
		logic             hit;
		logic [7:0]       found_willingness;
		logic             willingness_ok;
		logic [7:0]       max_willingness;
		logic [7:0]       next_max_willingness;
		logic [CNT_W-1:0] entry_count;
		logic             full_drop;
	} rsp_t;

endpackage

### rtl/core/ntrq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; depends on nothing.
module ntrq_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/neighbor_table_with_rank_query_top.sv
// Top level of the neighbour table with rank query.
// Depends on ntrq_pkg and on ntrq_ram for the entry memory.

// Each request beat is served by one pass over all NEIGHBOR_SLOTS slots of the entry
// memory through its single read port, followed by a write-back step. A new request is
// accepted only after the write-back of the previous one, and a response still held by
// the consumer delays that write-back. The pass finds the matching address and the
// lowest free slot, and it gathers the count and the two largest willingness values of
// all other entries; the write-back step folds in the new value. The response waits in
// an output register, so the next request may be accepted before it is taken. Valid bits
// sit in flip-flops and are cleared by reset; no clearing pass is needed.
module neighbor_table_with_rank_query_top import ntrq_pkg::*; #(
	parameter int NEIGHBOR_SLOTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int IW = $clog2(NEIGHBOR_SLOTS);
	localparam int CW = $clog2(NEIGHBOR_SLOTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(NEIGHBOR_SLOTS - 1);

	state_t state_q, state_d;

	req_t                      req_q;
	logic [NEIGHBOR_SLOTS-1:0] valid_q;
	logic [IW-1:0]             rd_idx_q;
	logic                      issue_q;

	// Read pipeline stage that lines up with the memory's read data.
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	logic          rd_last_s1;
	logic          ent_vld_s1;
	entry_t        rdata;

	// Scan results.
	logic          hit_q;
	logic [7:0]    found_q;
	logic [IW-1:0] slot_q;
	logic          free_found_q;
	logic [IW-1:0] free_slot_q;
	logic [7:0]    m1_q, m2_q;
	logic [CW-1:0] cnt_q;

	logic rsp_valid_q;
	rsp_t rsp_q;

	logic start, issue, finish_go;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake controls.
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		issue     = 1'b0;
		finish_go = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue = issue_q;
				if (rd_vld_s1 && rd_last_s1) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				finish_go = !rsp_valid_q || rsp_ready;
				if (finish_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign start = req_valid && req_ready;

	// Match test on the entry that the memory returns this cycle.
	logic is_ins, is_era, is_lku;
	logic match_c, excl_c;
	logic [7:0] m1_c, m2_c;

	assign is_ins = req_q.func == FUNC_INSERT;
	assign is_era = req_q.func == FUNC_ERASE;
	assign is_lku = req_q.func == FUNC_LOOKUP;

	always_comb begin
		match_c = ent_vld_s1 && !hit_q && (is_ins || is_era || is_lku) &&
			(rdata.addr == req_q.neighbor_addr) &&
			(!(is_lku && req_q.match_willingness) || rdata.will == req_q.willingness);
		// The entry that an insert or erase changes is left out of the running statistics.
		excl_c = match_c && (is_ins || is_era);
		m1_c = m1_q;
		m2_c = m2_q;
		if (rdata.will > m1_q) begin
			m1_c = rdata.will;
			m2_c = m1_q;
		end else if (rdata.will > m2_q) begin
			m2_c = rdata.will;
		end
	end

	// Read issue, read pipeline and scan accumulation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (start) begin
				issue_q <= 1'b1;
			end else if (issue && rd_idx_q == LAST_IDX) begin
				issue_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1  <= rd_idx_q;
		rd_last_s1 <= rd_idx_q == LAST_IDX;
		ent_vld_s1 <= valid_q[rd_idx_q];
		if (start) begin
			req_q        <= req;
			rd_idx_q     <= '0;
			hit_q        <= 1'b0;
			found_q      <= '0;
			free_found_q <= 1'b0;
			m1_q         <= '0;
			m2_q         <= '0;
			cnt_q        <= '0;
		end else begin
			if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (rd_vld_s1) begin
				if (match_c) begin
					hit_q   <= 1'b1;
					found_q <= rdata.will;
					slot_q  <= rd_idx_s1;
				end
				if (!ent_vld_s1 && !free_found_q) begin
					free_found_q <= 1'b1;
					free_slot_q  <= rd_idx_s1;
				end
				if (ent_vld_s1 && !excl_c) begin
					m1_q  <= m1_c;
					m2_q  <= m2_c;
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Final statistics with the inserted or updated value folded in.
	logic          add_en;
	logic [7:0]    m1_f, m2_f;
	logic [CW-1:0] cnt_f;
	logic [CW+CNT_W-1:0] cnt_ext;
	logic          wr_en;
	logic [IW-1:0] wr_slot;
	rsp_t          rsp_c;

	always_comb begin
		add_en = is_ins && (hit_q || free_found_q);
		m1_f   = m1_q;
		m2_f   = m2_q;
		if (add_en) begin
			if (req_q.willingness > m1_q) begin
				m1_f = req_q.willingness;
				m2_f = m1_q;
			end else if (req_q.willingness > m2_q) begin
				m2_f = req_q.willingness;
			end
		end
		cnt_f = cnt_q + CW'(add_en);
		if (cnt_f == CW'(1)) begin
			m2_f = m1_f;
		end
		cnt_ext = {{CNT_W{1'b0}}, cnt_f};
		wr_en   = add_en;
		wr_slot = hit_q ? slot_q : free_slot_q;

		rsp_c.hit                  = hit_q;
		rsp_c.found_willingness    = found_q;
		rsp_c.willingness_ok       = req_q.willingness >= m1_f;
		rsp_c.max_willingness      = m1_f;
		rsp_c.next_max_willingness = m2_f;
		rsp_c.entry_count          = cnt_ext[CNT_W-1:0];
		rsp_c.full_drop            = is_ins && !hit_q && !free_found_q;
	end

	// Valid bits: set by an insert into a free slot, cleared by an erase that hits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (finish_go) begin
			if (is_ins && !hit_q && free_found_q) begin
				valid_q[free_slot_q] <= 1'b1;
			end else if (is_era && hit_q) begin
				valid_q[slot_q] <= 1'b0;
			end
		end
	end

	// Entry memory: one read per slot during the pass, one write at the end when an insert stores its entry.
	ntrq_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(NEIGHBOR_SLOTS)
	) u_entry_ram (
		.clk  (clk),
		.we   (finish_go && wr_en),
		.waddr(wr_slot),
		.wdata({req_q.neighbor_addr, req_q.willingness}),
		.re   (issue),
		.raddr(rd_idx_q),
		.rdata(rdata)
	);

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			rsp_q <= rsp_c;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/core/ntrq_checker.sv
// Port-level checker for the neighbour table, bound to its top level.
// Depends on ntrq_pkg and on the top level neighbor_table_with_rank_query_top.
module ntrq_checker import ntrq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// A stalled response beat holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// A dropped insert never reports a hit.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.full_drop |-> !rsp.hit)
		else $error("full drop reported together with a hit");

	// The second largest value never exceeds the largest.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.next_max_willingness <= rsp.max_willingness)
		else $error("second maximum above maximum");

	// Without a hit the found willingness reads zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.hit |-> rsp.found_willingness == 8'd0)
		else $error("found willingness set without a hit");

endmodule

bind neighbor_table_with_rank_query_top ntrq_checker u_ntrq_checker (.*);

### test/neighbor_table_with_rank_query_top_test.sv
// Self-checking bench for the neighbour table: directed and random request beats are
// scored against an in-bench table predictor. Depends on ntrq_pkg and the table top level.
module neighbor_table_with_rank_query_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ntrq_pkg::*;

	localparam int NEIGHBOR_SLOTS = 16;
	localparam int LATENCY        = NEIGHBOR_SLOTS + 3;
	localparam int RANDOM_BEATS   = 1400;
	localparam int ADDR_POOL      = 24;
	localparam int CYCLE_LIMIT    = 1000000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Shadow copy of the table, updated as each request beat is accepted.
	bit          nbr_valid [NEIGHBOR_SLOTS];
	logic [31:0] nbr_addr  [NEIGHBOR_SLOTS];
	logic [7:0]  nbr_will  [NEIGHBOR_SLOTS];

	req_t        pending_reqs[$];
	rsp_t        awaited_rsps[$];
	logic [31:0] addr_pool[ADDR_POOL];
	int          errors     = 0;
	int          cycles     = 0;
	int          send_hold  = 0;
	int          take_hold  = 0;
	bit          send_burst = 1'b0;
	bit          take_burst = 1'b0;

	neighbor_table_with_rank_query_top #(
		.NEIGHBOR_SLOTS(NEIGHBOR_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// Applies one request to the shadow table and returns the response it should produce.
	function automatic rsp_t table_apply(req_t r);
		rsp_t   res;
		func_t  op;
		int     slot;
		int     count;
		int     top;
		int     second;
		res  = '0;
		op   = func_t'(r.func);
		slot = -1;
		for (int i = 0; i < NEIGHBOR_SLOTS; i++) begin
			if (slot < 0 && nbr_valid[i] && nbr_addr[i] == r.neighbor_addr &&
					(op != FUNC_LOOKUP || !r.match_willingness ||
					nbr_will[i] == r.willingness)) begin
				slot = i;
			end
		end
		case (op)
			FUNC_INSERT: begin
				if (slot >= 0) begin
					res.hit = 1'b1;
					res.found_willingness = nbr_will[slot];
					nbr_will[slot] = r.willingness;
				end else begin
					for (int i = 0; i < NEIGHBOR_SLOTS; i++) begin
						if (slot < 0 && !nbr_valid[i]) begin
							slot = i;
						end
					end
					if (slot >= 0) begin
						nbr_valid[slot] = 1'b1;
						nbr_addr[slot]  = r.neighbor_addr;
						nbr_will[slot]  = r.willingness;
					end else begin
						res.full_drop = 1'b1;
					end
				end
			end
			FUNC_ERASE: begin
				if (slot >= 0) begin
					res.hit = 1'b1;
					res.found_willingness = nbr_will[slot];
					nbr_valid[slot] = 1'b0;
				end
			end
			FUNC_LOOKUP: begin
				if (slot >= 0) begin
					res.hit = 1'b1;
					res.found_willingness = nbr_will[slot];
				end
			end
			default: begin
			end
		endcase
		// Statistics over the table as it stands after the operation.
		count  = 0;
		top    = 0;
		second = 0;
		for (int i = 0; i < NEIGHBOR_SLOTS; i++) begin
			if (nbr_valid[i]) begin
				count++;
				if (nbr_will[i] > top) begin
					second = top;
					top    = nbr_will[i];
				end else if (nbr_will[i] > second) begin
					second = nbr_will[i];
				end
			end
		end
		if (count == 1) begin
			second = top;
		end
		res.willingness_ok       = (r.willingness >= top);
		res.max_willingness      = top[7:0];
		res.next_max_willingness = second[7:0];
		res.entry_count          = count[CNT_W-1:0];
		return res;
	endfunction

	function automatic req_t make_req(func_t op, logic [31:0] a, logic [7:0] w, logic m);
		req_t r;
		r.func              = op;
		r.neighbor_addr     = a;
		r.willingness       = w;
		r.match_willingness = m;
		return r;
	endfunction

	// Appends one request beat to the tail of the pending queue.
	function automatic void queue_req(req_t r);
		pending_reqs = {pending_reqs, r};
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_len(bit burst);
		int roll;
		roll = $urandom_range(0, 99);
		if (burst || roll < 55) begin
			return 0;
		end
		if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 50);
	endfunction

	task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Request driver: one beat from the pending queue at a time, with random gaps.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_ready) begin
			if (send_hold > 0) begin
				send_hold--;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				req       <= pending_reqs.pop_front();
				req_valid <= 1'b1;
				if ($urandom_range(0, 99) == 0) begin
					send_burst = !send_burst;
				end
				send_hold = idle_len(send_burst);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Response back-pressure: stalls of random length, with stall-free stretches.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 499) == 0) begin
				take_burst = !take_burst;
			end
			if (take_hold > 0) begin
				take_hold--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) begin
					take_hold = idle_len(take_burst);
				end
			end
		end
	end

	// Monitor: predict on each accepted request beat, score each accepted response beat.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				awaited_rsps = {awaited_rsps, table_apply(req)};
			end
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsps.size() == 0) begin
					$display("%0t: response beat with none expected, got %h", $time, rsp);
					errors++;
				end else begin
					want = awaited_rsps.pop_front();
					field_check("hit", 32'(want.hit), 32'(rsp.hit));
					field_check("found_willingness", 32'(want.found_willingness),
						32'(rsp.found_willingness));
					field_check("willingness_ok", 32'(want.willingness_ok),
						32'(rsp.willingness_ok));
					field_check("max_willingness", 32'(want.max_willingness),
						32'(rsp.max_willingness));
					field_check("next_max_willingness", 32'(want.next_max_willingness),
						32'(rsp.next_max_willingness));
					field_check("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
					field_check("full_drop", 32'(want.full_drop), 32'(rsp.full_drop));
				end
			end
		end
	end

	// Watchdog on the cycle count.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int          ins_w;
		int          roll;
		func_t       op;
		logic [31:0] a;
		logic [7:0]  w;
		for (int i = 0; i < NEIGHBOR_SLOTS; i++) begin
			nbr_valid[i] = 1'b0;
			nbr_addr[i]  = '0;
			nbr_will[i]  = '0;
		end
		addr_pool[0] = 32'h0000_0000;
		addr_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < ADDR_POOL; i++) begin
			addr_pool[i] = $urandom;
		end

		// Directed: empty table, unused code, extremes, update, matched lookups, fill to full.
		queue_req(make_req(FUNC_LOOKUP, 32'h0000_0000, 8'h00, 1'b0));
		queue_req(make_req(FUNC_ERASE,  32'hFFFF_FFFF, 8'hFF, 1'b0));
		queue_req(make_req(FUNC_NOP,    32'h1234_5678, 8'h55, 1'b1));
		queue_req(make_req(FUNC_INSERT, 32'h0000_0000, 8'h00, 1'b1));
		queue_req(make_req(FUNC_INSERT, 32'hFFFF_FFFF, 8'hFF, 1'b0));
		queue_req(make_req(FUNC_INSERT, 32'hFFFF_FFFF, 8'h80, 1'b1));
		queue_req(make_req(FUNC_LOOKUP, 32'hFFFF_FFFF, 8'h80, 1'b1));
		queue_req(make_req(FUNC_LOOKUP, 32'hFFFF_FFFF, 8'h7F, 1'b1));
		queue_req(make_req(FUNC_LOOKUP, 32'h0000_0000, 8'hFF, 1'b0));
		queue_req(make_req(FUNC_ERASE,  32'h0000_0000, 8'h00, 1'b1));
		for (int i = 1; i < NEIGHBOR_SLOTS; i++) begin
			queue_req(make_req(FUNC_INSERT, 32'h0A00_0000 + i,
				8'((i % 5) * 60), 1'b0));
		end
		queue_req(make_req(FUNC_INSERT, 32'h55AA_55AA, 8'h01, 1'b0));
		queue_req(make_req(FUNC_LOOKUP, 32'hFFFF_FFFF, 8'h80, 1'b1));

		// Random: phases that lean towards filling or draining the table.
		ins_w = 45;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 100 == 0) begin
				case ($urandom_range(0, 2))
					0:       ins_w = 20;
					1:       ins_w = 45;
					default: ins_w = 70;
				endcase
			end
			roll = $urandom_range(0, 99);
			if (roll < ins_w) begin
				op = FUNC_INSERT;
			end else if (roll < ins_w + (95 - ins_w) / 2) begin
				op = FUNC_ERASE;
			end else if (roll < 95) begin
				op = FUNC_LOOKUP;
			end else begin
				op = FUNC_NOP;
			end
			a = ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, ADDR_POOL - 1)]
				: $urandom;
			// A narrow set of values makes duplicates and willingness matches common.
			if ($urandom_range(0, 1)) begin
				w = 8'($urandom_range(0, 255));
			end else begin
				case ($urandom_range(0, 5))
					0:       w = 8'h00;
					1:       w = 8'h01;
					2:       w = 8'h07;
					3:       w = 8'h80;
					4:       w = 8'hFE;
					default: w = 8'hFF;
				endcase
			end
			queue_req(make_req(op, a, w, 1'($urandom_range(0, 1))));
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		do begin
			@(posedge clk);
		end while (pending_reqs.size() > 0 || req_valid || awaited_rsps.size() > 0);
		repeat (4 * LATENCY) @(posedge clk);
		if (errors == 0 && awaited_rsps.size() == 0) begin
			$display("Regression PASS");
		end else begin
			if (awaited_rsps.size() > 0) begin
				$display("%0t: %0d response beats never arrived", $time, awaited_rsps.size());
			end
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
